/* rtl/gbhe_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GPIB byte handshake engine package
// Shared types and constants for the source and acceptor handshake logic.
// ----------------------------------------------------------------------------
package gbhe_pkg;

    localparam int unsigned TMO_W = 20;
    localparam logic [TMO_W-1:0] TIMEOUT_RESET = 20'd10000;

    // Command codes.
    localparam logic [1:0] CMD_TICK = 2'd0;
    localparam logic [1:0] CMD_SEND = 2'd1;
    localparam logic [1:0] CMD_RECV = 2'd2;

    // Bit positions in the sampled line levels and the drive vector.
    localparam int unsigned L_DAV  = 0;
    localparam int unsigned L_NRFD = 1;
    localparam int unsigned L_NDAC = 2;
    localparam int unsigned L_ATN  = 3;
    localparam int unsigned L_EOI  = 4;
    localparam int unsigned L_IFC  = 5;
    localparam int unsigned L_SRQ  = 6;
    localparam int unsigned L_REN  = 7;

    // Bit positions in the result flags.
    localparam int unsigned F_EOI = 0;
    localparam int unsigned F_ATN = 1;
    localparam int unsigned F_SRQ = 2;
    localparam int unsigned F_REN = 3;
    localparam int unsigned F_PP  = 4;
    localparam int unsigned F_IFC = 5;
    localparam int unsigned F_TMO = 6;

    typedef enum logic [17:0] {
        PH_IDLE              = 18'b000000000000000001,
        PH_TX_START          = 18'b000000000000000010,
        PH_TX_WAIT_READY     = 18'b000000000000000100,
        PH_TX_PUT            = 18'b000000000000001000,
        PH_TX_WAIT_NRFD_HI   = 18'b000000000000010000,
        PH_TX_DAV_LOW        = 18'b000000000000100000,
        PH_TX_WAIT_NDAC_HI   = 18'b000000000001000000,
        PH_TX_DAV_HI         = 18'b000000000010000000,
        PH_TX_WAIT_NDAC_LOW  = 18'b000000000100000000,
        PH_TX_FINISH         = 18'b000000001000000000,
        PH_TX_ERROR          = 18'b000000010000000000,
        PH_RX_START          = 18'b000000100000000000,
        PH_RX_WAIT_DAV_LOW   = 18'b000001000000000000,
        PH_RX_DAV_LOW        = 18'b000010000000000000,
        PH_RX_WAIT_DAV_HI    = 18'b000100000000000000,
        PH_RX_DAV_HI         = 18'b001000000000000000,
        PH_RX_FINISH         = 18'b010000000000000000,
        PH_RX_ERROR          = 18'b100000000000000000
    } gbhe_phase_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] tx_byte;
        logic       tx_atn;
        logic       tx_eoi;
        logic [7:0] bus_level;
        logic [7:0] line_levels;
    } gbhe_in_t;

    typedef struct packed {
        logic [4:0] drive_low;
        logic       bus_drive_en;
        logic [7:0] bus_drive_val;
        logic       busy_res;
        logic       done_res;
        logic [7:0] result_byte;
        logic [6:0] result_flags;
    } gbhe_out_t;

    typedef struct packed {
        gbhe_phase_t phase;
        logic [7:0]  held_byte;
        logic [6:0]  held_flags;
        logic [4:0]  line_drive;
        logic        data_en;
        logic [7:0]  data_val;
    } gbhe_state_t;

endpackage

/* rtl/gbhe_timer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GPIB handshake timeout timer
// Down-counter that runs one step per processed tick and is rearmed by the
// handshake logic.
// ----------------------------------------------------------------------------
module gbhe_timer
    import gbhe_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             advance,
    input  logic             arm,
    input  logic [TMO_W-1:0] ticks,
    output logic             expired_now
);

    logic [TMO_W-1:0] count_reg, count_next;
    logic             exp_reg, exp_next;

    // The step sees the count as it stood before the countdown for the current tick.
    assign expired_now = exp_reg | (count_reg == '0);

    always_comb begin
        count_next = count_reg;
        exp_next   = exp_reg;
        if (advance) begin
            if (arm) begin
                count_next = ticks;
                exp_next   = 1'b0;
            end else if (count_reg != '0) begin
                count_next = count_reg - 1'b1;
            end else begin
                exp_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            exp_reg   <= 1'b1;
        end else begin
            count_reg <= count_next;
            exp_reg   <= exp_next;
        end
    end

`ifndef SYNTH
    a_arm_loads : assert property (@(posedge aclk) disable iff (!aresetn)
        advance && arm |=> !exp_reg && count_reg == $past(ticks))
        else $error("timer did not load on arm");

    a_hold_idle : assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(count_reg) && $stable(exp_reg))
        else $error("timer moved without a processed tick");
`endif

endmodule

/* rtl/gbhe_step.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GPIB handshake step logic
// Next state and result for one tick of the source or acceptor handshake.
// ----------------------------------------------------------------------------
module gbhe_step
    import gbhe_pkg::*;
(
    input  gbhe_state_t cur,
    input  gbhe_in_t    item,
    input  logic        expired,
    output gbhe_state_t nxt,
    output logic        arm,
    output gbhe_out_t   res
);

    logic [7:0] lv;
    logic [7:0] rx_val;
    logic       done;

    assign lv = item.line_levels;

    always_comb begin
        nxt    = cur;
        arm    = 1'b0;
        done   = 1'b0;
        rx_val = ~item.bus_level;

        if (cur.phase == PH_IDLE) begin
            if (item.cmd == CMD_SEND) begin
                nxt.held_byte  = item.tx_byte;
                nxt.held_flags = '0;
                nxt.held_flags[F_ATN] = item.tx_atn;
                nxt.held_flags[F_EOI] = item.tx_eoi;
                nxt.line_drive = '0;
                nxt.data_en    = 1'b0;
                nxt.data_val   = '0;
                nxt.phase      = PH_TX_START;
            end else if (item.cmd == CMD_RECV) begin
                nxt.held_byte  = '0;
                nxt.held_flags = '0;
                nxt.line_drive = '0;
                nxt.line_drive[L_NDAC] = 1'b1;
                nxt.data_en    = 1'b0;
                nxt.data_val   = '0;
                nxt.phase      = PH_RX_START;
            end
        end else begin
            // Parallel poll shows as ATN and EOI both low.
            if (!lv[L_ATN] && !lv[L_EOI]) begin
                nxt.held_flags[F_PP] = 1'b1;
            end
            if (!lv[L_IFC]) begin
                // Interface clear ends the transaction with the drives as they are.
                nxt.held_flags[F_IFC] = 1'b1;
                done = 1'b1;
            end else begin
                unique case (cur.phase)
                    PH_TX_START: begin
                        if (lv[L_DAV]) begin
                            arm       = 1'b1;
                            nxt.phase = PH_TX_WAIT_READY;
                        end
                    end
                    PH_TX_WAIT_READY: begin
                        if (lv[L_NRFD]) begin
                            if (!lv[L_NDAC]) begin
                                nxt.phase = PH_TX_PUT;
                            end
                        end else if (expired) begin
                            nxt.held_flags[F_TMO] = 1'b1;
                            nxt.phase = PH_TX_ERROR;
                        end
                    end
                    PH_TX_PUT: begin
                        if (cur.held_flags[F_ATN]) begin
                            nxt.line_drive[L_ATN] = 1'b1;
                        end
                        if (cur.held_flags[F_EOI]) begin
                            nxt.line_drive[L_EOI] = 1'b1;
                        end
                        nxt.data_en  = 1'b1;
                        nxt.data_val = ~cur.held_byte;
                        arm          = 1'b1;
                        nxt.phase    = PH_TX_WAIT_NRFD_HI;
                    end
                    PH_TX_WAIT_NRFD_HI: begin
                        if (lv[L_NRFD]) begin
                            arm       = 1'b1;
                            nxt.phase = PH_TX_DAV_LOW;
                        end else if (expired) begin
                            nxt.held_flags[F_TMO] = 1'b1;
                            nxt.phase = PH_TX_ERROR;
                        end
                    end
                    PH_TX_DAV_LOW: begin
                        nxt.line_drive[L_DAV] = 1'b1;
                        arm       = 1'b1;
                        nxt.phase = PH_TX_WAIT_NDAC_HI;
                    end
                    PH_TX_WAIT_NDAC_HI: begin
                        if (lv[L_NDAC]) begin
                            nxt.phase = PH_TX_DAV_HI;
                        end else if (expired) begin
                            nxt.held_flags[F_TMO] = 1'b1;
                            nxt.phase = PH_TX_ERROR;
                        end
                    end
                    PH_TX_DAV_HI: begin
                        nxt.line_drive[L_DAV] = 1'b0;
                        nxt.line_drive[L_ATN] = 1'b0;
                        nxt.line_drive[L_EOI] = 1'b0;
                        nxt.data_en  = 1'b0;
                        nxt.data_val = '0;
                        arm          = 1'b1;
                        nxt.phase    = PH_TX_WAIT_NDAC_LOW;
                    end
                    PH_TX_WAIT_NDAC_LOW: begin
                        if (!lv[L_NDAC]) begin
                            nxt.phase = PH_TX_FINISH;
                        end else begin
                            // After the last data byte, hold off the listeners.
                            if (!cur.held_flags[F_ATN] && cur.held_flags[F_EOI]) begin
                                nxt.line_drive[L_NRFD] = 1'b1;
                            end
                            if (expired) begin
                                nxt.held_flags[F_TMO] = 1'b1;
                                nxt.phase = PH_TX_ERROR;
                            end
                        end
                    end
                    PH_TX_FINISH: begin
                        done = 1'b1;
                    end
                    PH_TX_ERROR: begin
                        nxt.line_drive[L_DAV]  = 1'b0;
                        nxt.line_drive[L_ATN]  = 1'b0;
                        nxt.line_drive[L_EOI]  = 1'b0;
                        nxt.line_drive[L_NRFD] = 1'b1;
                        nxt.data_en  = 1'b0;
                        nxt.data_val = '0;
                        done = 1'b1;
                    end
                    PH_RX_START: begin
                        nxt.line_drive[L_NRFD] = 1'b0;
                        nxt.phase = PH_RX_WAIT_DAV_LOW;
                    end
                    PH_RX_WAIT_DAV_LOW: begin
                        if (!lv[L_DAV]) begin
                            nxt.phase = PH_RX_DAV_LOW;
                        end
                    end
                    PH_RX_DAV_LOW: begin
                        // Commands carry seven bits; bit 7 is stripped under ATN.
                        if (!lv[L_ATN]) begin
                            rx_val[7] = 1'b0;
                        end
                        nxt.held_byte = cur.held_byte | rx_val;
                        nxt.held_flags[F_EOI] = cur.held_flags[F_EOI] | !lv[L_EOI];
                        nxt.held_flags[F_ATN] = cur.held_flags[F_ATN] | !lv[L_ATN];
                        nxt.held_flags[F_SRQ] = cur.held_flags[F_SRQ] | !lv[L_SRQ];
                        nxt.held_flags[F_REN] = cur.held_flags[F_REN] | !lv[L_REN];
                        nxt.line_drive[L_NRFD] = 1'b1;
                        nxt.line_drive[L_NDAC] = 1'b0;
                        arm       = 1'b1;
                        nxt.phase = PH_RX_WAIT_DAV_HI;
                    end
                    PH_RX_WAIT_DAV_HI: begin
                        if (expired) begin
                            nxt.held_flags[F_TMO] = 1'b1;
                            nxt.phase = PH_RX_ERROR;
                        end else if (lv[L_DAV]) begin
                            nxt.phase = PH_RX_DAV_HI;
                        end
                    end
                    PH_RX_DAV_HI: begin
                        nxt.line_drive[L_NDAC] = 1'b1;
                        nxt.phase = PH_RX_FINISH;
                    end
                    PH_RX_FINISH: begin
                        nxt.line_drive[L_NDAC] = 1'b1;
                        done = 1'b1;
                    end
                    PH_RX_ERROR: begin
                        nxt.line_drive[L_NDAC] = 1'b1;
                        nxt.line_drive[L_NRFD] = 1'b1;
                        done = 1'b1;
                    end
                    default: begin
                        done = 1'b1;
                    end
                endcase
            end
            if (done) begin
                nxt.phase = PH_IDLE;
            end
        end
    end

    always_comb begin
        res.drive_low     = nxt.line_drive;
        res.bus_drive_en  = nxt.data_en;
        res.bus_drive_val = nxt.data_val;
        res.busy_res      = (nxt.phase != PH_IDLE);
        res.done_res      = done;
        res.result_byte   = done ? nxt.held_byte : 8'h00;
        res.result_flags  = done ? nxt.held_flags : 7'h00;
    end

endmodule

/* rtl/gpib_byte_handshake_engine_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// GPIB byte handshake engine
// IEEE-488 three-wire source and acceptor handshake, one timer tick per
// transaction on the input channel.
// ----------------------------------------------------------------------------
// Usage:
//   Each input transaction (s_valid/s_ready, payload s_item) is one timer tick
//   with the sampled bus lines and an optional send or receive command. Each
//   tick yields exactly one result transaction (m_valid/m_ready, payload
//   m_item) with the line drives, busy and done status, and on completion the
//   transferred byte and its flags.
//   A tick is taken into an input register, stepped through the handshake
//   logic and held in the result register, from which the result is presented.
//   Throughput is one tick per cycle while the receiver does not stall; the
//   handshake state and timer registers are the only loops.
//   The user must write the timeout limit through cfg_we/cfg_wdata only while
//   no tick is in flight, unenforced by the block; it resets to 10000 ticks.
//   Reset idles the handshake, pulls NRFD and NDAC low and floats the data
//   lines. When the receiver stalls, the result register holds and the input
//   register fills, after which s_ready drops until results drain.
// ----------------------------------------------------------------------------
module gpib_byte_handshake_engine_top
    import gbhe_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic [TMO_W-1:0] cfg_wdata,
    input  logic             s_valid,
    output logic             s_ready,
    input  gbhe_in_t         s_item,
    output logic             m_valid,
    input  logic             m_ready,
    output gbhe_out_t        m_item
);

    logic [TMO_W-1:0] timeout_ticks_reg;
    logic             in_valid_reg;
    gbhe_in_t         in_item_reg;
    logic             out_valid_reg;
    gbhe_out_t        out_item_reg;
    gbhe_state_t      state_reg, state_next;
    gbhe_out_t        step_res;
    logic             step_arm;
    logic             expired_now;
    logic             advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

    gbhe_timer u_timer (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (advance),
        .arm         (step_arm),
        .ticks       (timeout_ticks_reg),
        .expired_now (expired_now)
    );

    gbhe_step u_step (
        .cur     (state_reg),
        .item    (in_item_reg),
        .expired (expired_now),
        .nxt     (state_next),
        .arm     (step_arm),
        .res     (step_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_ticks_reg <= TIMEOUT_RESET;
        end else if (cfg_we) begin
            timeout_ticks_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_item_reg <= step_res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.phase      <= PH_IDLE;
            state_reg.held_byte  <= '0;
            state_reg.held_flags <= '0;
            state_reg.line_drive <= 5'b00110;
            state_reg.data_en    <= 1'b0;
            state_reg.data_val   <= '0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTH
    a_done_not_busy : assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_item_reg.done_res |-> !out_item_reg.busy_res)
        else $error("completed transaction still reports busy");

    a_result_zero : assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !out_item_reg.done_res |->
            out_item_reg.result_byte == 8'h00 && out_item_reg.result_flags == 7'h00)
        else $error("result fields set without completion");

    a_stall_full : assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> in_valid_reg && out_valid_reg && !m_ready)
        else $error("input stalled while a stage was free");
`endif

endmodule
